// ===== src/vatu_pkg.sv =====
package vatu_pkg;

    localparam int PAGE_BYTES  = 128;
    localparam int TLB_ENTRIES = 4;
    localparam int TABLE_DEPTH = 64;

    localparam int VA_W     = 32;
    localparam int OFF_W    = $clog2(PAGE_BYTES);
    localparam int VPN_W    = VA_W - OFF_W;
    localparam int FRAME_W  = 16;
    localparam int PA_W     = 23;
    localparam int CNT_W    = 16;
    localparam int OP_W     = 3;
    localparam int FAULT_W  = 3;
    localparam int IDX_W    = 6;
    localparam int PAGE_W   = 25;
    localparam int TEI_W    = 7;
    localparam int LIMIT_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam int PTAB_AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TLB_IW   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int LIM_W    = $clog2(TABLE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_XLATE = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_PT = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_TLB = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_PT = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_TLB = 3'd4;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_ADDR = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_PAGE = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_RO   = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_BUS  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_TLB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEI     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               valid;
        logic               ro;
        logic               dirty;
        logic               refd;
        logic [CNT_W-1:0]   count;
    } pte_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        pte_t              e;
    } tlbe_t;

    typedef struct packed {
        logic               we;
        logic [PTAB_AW-1:0] addr;
        pte_t               data;
    } pt_wr_t;

endpackage

// ===== src/vatu_ptab.sv =====
// Page table store: one synchronous read port, one write port.
// Entries never written since reset read as all zeros (invalid).
module vatu_ptab
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [vatu_pkg::PTAB_AW-1:0]  rd_addr,
    output vatu_pkg::pte_t                rd_data,
    input  vatu_pkg::pt_wr_t              wr
);

    vatu_pkg::pte_t mem [vatu_pkg::TABLE_DEPTH];
    logic [vatu_pkg::TABLE_DEPTH-1:0] vld_reg;
    vatu_pkg::pte_t rd_data_reg;
    logic           rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== src/virtual_address_translation_unit.sv =====
// Virtual address translation unit.
// Command channel: an item (op and operands) is taken at a clock edge with
// start high and busy low. Ops: translate, write/read page table entry,
// write/read TLB entry. Operands are held internally, so they need only be
// valid at that edge.
// Result: done is high for exactly one cycle with fault, phys_addr and the
// entry marks on their ports; the receiver cannot stall and must take it.
// Sequence: done rises at the end of the execute state that follows the
// accepting edge. busy is high during that execute state, so a new item can
// be taken at the edge that ends the done cycle, and none before. The page
// table memory is read into a register at the accepting edge; compare, fault
// check and write-back follow in the execute state. The 4-entry TLB sits in
// flops and is compared in parallel during the execute state.
// Configuration: cfg_valid/cfg_ready write channel (cfg_ready is always
// high); index 0 use_tlb, 1 table_entries_in_use, 2 phys_page_limit. Write
// only while idle.
// Reset: all page table and TLB entries read as invalid and cleared, config
// returns to linear mode, 64 entries in use, 128 frames. No clearing pass.
module virtual_address_translation_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [vatu_pkg::OP_W-1:0]         op,
    input  logic [vatu_pkg::VA_W-1:0]         virt_addr,
    input  logic [1:0]                        access_size,
    input  logic                              is_write,
    input  logic [vatu_pkg::IDX_W-1:0]        entry_index,
    input  logic [vatu_pkg::PAGE_W-1:0]       entry_page,
    input  logic [vatu_pkg::FRAME_W-1:0]      entry_frame,
    input  logic                              entry_valid,
    input  logic                              entry_read_only,
    output logic                              done,
    output logic [vatu_pkg::FAULT_W-1:0]      fault,
    output logic [vatu_pkg::PA_W-1:0]         phys_addr,
    output logic                              dirty_bit,
    output logic                              referenced_bit,
    output logic [vatu_pkg::CNT_W-1:0]        reference_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vatu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vatu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0] state_reg, state_next;
    logic       accept;

    // config
    logic                          use_tlb_reg;
    logic [vatu_pkg::TEI_W-1:0]    tei_reg;
    logic [vatu_pkg::LIMIT_W-1:0]  limit_reg;

    // captured command
    logic [vatu_pkg::OP_W-1:0]     op_reg;
    logic [vatu_pkg::VA_W-1:0]     va_reg;
    logic [1:0]                    size_reg;
    logic                          wr_reg;
    logic [vatu_pkg::IDX_W-1:0]    idx_reg;
    logic [vatu_pkg::PAGE_W-1:0]   page_reg;
    logic [vatu_pkg::FRAME_W-1:0]  frame_reg;
    logic                          valid_reg;
    logic                          ro_reg;

    // TLB in flops
    vatu_pkg::tlbe_t tlb_reg [vatu_pkg::TLB_ENTRIES];

    // result registers
    logic                          done_reg;
    logic [vatu_pkg::FAULT_W-1:0]  fault_reg, fault_next;
    logic [vatu_pkg::PA_W-1:0]     pa_reg, pa_next;
    logic                          dirty_reg, dirty_next;
    logic                          refd_reg, refd_next;
    logic [vatu_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    // page table port
    logic [vatu_pkg::PTAB_AW-1:0]  pt_rd_addr;
    vatu_pkg::pte_t                pt_rd;
    vatu_pkg::pt_wr_t              pt_wr;

    // exec-cycle signals
    logic [vatu_pkg::VPN_W-1:0]    vpn;
    logic [vatu_pkg::OFF_W-1:0]    off;
    logic [vatu_pkg::LIM_W-1:0]    lim;
    logic                          misalign;
    logic                          hit;
    logic [vatu_pkg::TLB_IW-1:0]   hit_idx;
    logic [vatu_pkg::TLB_IW-1:0]   tlb_ridx;
    vatu_pkg::pte_t                ent;
    vatu_pkg::pte_t                upd;
    logic                          tlb_we;
    logic [vatu_pkg::TLB_IW-1:0]   tlb_widx;
    vatu_pkg::tlbe_t               tlb_wdata;
    logic                          pt_idx_bad;
    logic                          tlb_idx_bad;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign pt_rd_addr = (op == vatu_pkg::OP_XLATE)
                      ? vatu_pkg::PTAB_AW'(virt_addr[vatu_pkg::VA_W-1:vatu_pkg::OFF_W])
                      : vatu_pkg::PTAB_AW'(entry_index);

    vatu_ptab u_ptab
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd),
        .wr      (pt_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_tlb_reg <= 1'b0;
            tei_reg     <= vatu_pkg::TEI_W'(64);
            limit_reg   <= vatu_pkg::LIMIT_W'(128);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vatu_pkg::CFG_USE_TLB: use_tlb_reg <= cfg_data[0];
                vatu_pkg::CFG_TEI:     tei_reg     <= cfg_data[vatu_pkg::TEI_W-1:0];
                vatu_pkg::CFG_LIMIT:   limit_reg   <= cfg_data[vatu_pkg::LIMIT_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            va_reg    <= virt_addr;
            size_reg  <= access_size;
            wr_reg    <= is_write;
            idx_reg   <= entry_index;
            page_reg  <= entry_page;
            frame_reg <= entry_frame;
            valid_reg <= entry_valid;
            ro_reg    <= entry_read_only;
        end
        if (state_reg == S_EXEC)
        begin
            fault_reg <= fault_next;
            pa_reg    <= pa_next;
            dirty_reg <= dirty_next;
            refd_reg  <= refd_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vatu_pkg::TLB_ENTRIES; i++)
            begin
                tlb_reg[i] <= '0;
            end
        end
        else if (tlb_we)
        begin
            tlb_reg[tlb_widx] <= tlb_wdata;
        end
    end

    assign vpn = va_reg[vatu_pkg::VA_W-1:vatu_pkg::OFF_W];
    assign off = va_reg[vatu_pkg::OFF_W-1:0];
    assign lim = (32'(tei_reg) >= vatu_pkg::TABLE_DEPTH)
               ? vatu_pkg::LIM_W'(vatu_pkg::TABLE_DEPTH)
               : vatu_pkg::LIM_W'(tei_reg);
    assign misalign = (size_reg == 2'd3)
                   || (size_reg == 2'd2 && va_reg[1:0] != 2'b00)
                   || (size_reg == 2'd1 && va_reg[0]);
    assign pt_idx_bad  = (32'(idx_reg) >= vatu_pkg::TABLE_DEPTH);
    assign tlb_idx_bad = (32'(idx_reg) >= vatu_pkg::TLB_ENTRIES);
    assign tlb_ridx    = vatu_pkg::TLB_IW'(idx_reg);

    // lowest matching valid slot wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = vatu_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_reg[i].e.valid && tlb_reg[i].page == vpn)
            begin
                hit     = 1'b1;
                hit_idx = vatu_pkg::TLB_IW'(i);
            end
        end
    end

    assign ent = use_tlb_reg ? tlb_reg[hit_idx].e : pt_rd;

    always_comb
    begin
        upd       = ent;
        upd.dirty = ent.dirty | wr_reg;
        upd.refd  = 1'b1;
        upd.count = (ent.count != vatu_pkg::CNT_MAX) ? ent.count + 1'b1 : ent.count;
    end

    // entry writes only in the execute cycle
    always_comb
    begin
        fault_next = vatu_pkg::FAULT_NONE;
        pa_next    = '0;
        dirty_next = 1'b0;
        refd_next  = 1'b0;
        cnt_next   = '0;
        pt_wr      = '0;
        tlb_we     = 1'b0;
        tlb_widx   = hit_idx;
        tlb_wdata  = '0;
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                vatu_pkg::OP_XLATE:
                begin
                    if (misalign)
                    begin
                        fault_next = vatu_pkg::FAULT_ADDR;
                    end
                    else if (!use_tlb_reg && vpn >= vatu_pkg::VPN_W'(lim))
                    begin
                        fault_next = vatu_pkg::FAULT_ADDR;
                    end
                    else if (use_tlb_reg ? !hit : !pt_rd.valid)
                    begin
                        fault_next = vatu_pkg::FAULT_PAGE;
                    end
                    else if (ent.ro && wr_reg)
                    begin
                        fault_next = vatu_pkg::FAULT_RO;
                    end
                    else if ({1'b0, ent.frame} >= limit_reg)
                    begin
                        fault_next = vatu_pkg::FAULT_BUS;
                    end
                    else
                    begin
                        pa_next    = vatu_pkg::PA_W'({ent.frame, off});
                        dirty_next = upd.dirty;
                        refd_next  = upd.refd;
                        cnt_next   = upd.count;
                        if (use_tlb_reg)
                        begin
                            tlb_we    = 1'b1;
                            tlb_wdata = {tlb_reg[hit_idx].page, upd};
                        end
                        else
                        begin
                            pt_wr.we   = 1'b1;
                            pt_wr.addr = vatu_pkg::PTAB_AW'(vpn);
                            pt_wr.data = upd;
                        end
                    end
                end
                vatu_pkg::OP_WR_PT:
                begin
                    if (pt_idx_bad)
                    begin
                        fault_next = vatu_pkg::FAULT_ADDR;
                    end
                    else
                    begin
                        pt_wr.we         = 1'b1;
                        pt_wr.addr       = vatu_pkg::PTAB_AW'(idx_reg);
                        pt_wr.data.frame = frame_reg;
                        pt_wr.data.valid = valid_reg;
                        pt_wr.data.ro    = ro_reg;
                    end
                end
                vatu_pkg::OP_WR_TLB:
                begin
                    if (tlb_idx_bad)
                    begin
                        fault_next = vatu_pkg::FAULT_ADDR;
                    end
                    else
                    begin
                        tlb_we            = 1'b1;
                        tlb_widx          = tlb_ridx;
                        tlb_wdata.page    = page_reg;
                        tlb_wdata.e.frame = frame_reg;
                        tlb_wdata.e.valid = valid_reg;
                        tlb_wdata.e.ro    = ro_reg;
                    end
                end
                vatu_pkg::OP_RD_PT:
                begin
                    if (pt_idx_bad)
                    begin
                        fault_next = vatu_pkg::FAULT_ADDR;
                    end
                    else
                    begin
                        pa_next    = vatu_pkg::PA_W'({pt_rd.frame, {vatu_pkg::OFF_W{1'b0}}});
                        dirty_next = pt_rd.dirty;
                        refd_next  = pt_rd.refd;
                        cnt_next   = pt_rd.count;
                    end
                end
                vatu_pkg::OP_RD_TLB:
                begin
                    if (tlb_idx_bad)
                    begin
                        fault_next = vatu_pkg::FAULT_ADDR;
                    end
                    else
                    begin
                        pa_next    = vatu_pkg::PA_W'({tlb_reg[tlb_ridx].e.frame,
                                                      {vatu_pkg::OFF_W{1'b0}}});
                        dirty_next = tlb_reg[tlb_ridx].e.dirty;
                        refd_next  = tlb_reg[tlb_ridx].e.refd;
                        cnt_next   = tlb_reg[tlb_ridx].e.count;
                    end
                end
                default: ;
            endcase
        end
    end

    assign done            = done_reg;
    assign fault           = fault_reg;
    assign phys_addr       = pa_reg;
    assign dirty_bit       = dirty_reg;
    assign referenced_bit  = refd_reg;
    assign reference_count = cnt_reg;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_fault_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fault != vatu_pkg::FAULT_NONE) |->
            (phys_addr == '0 && reference_count == '0 && !referenced_bit && !dirty_bit))
        else $error("faulting result carries nonzero fields");

    a_xlate_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fault == vatu_pkg::FAULT_NONE && op_reg == vatu_pkg::OP_XLATE) |->
            (referenced_bit && reference_count != '0 && (dirty_bit || !wr_reg)))
        else $error("successful translation without updated marks");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_wr.we || tlb_we) |-> (state_reg == S_EXEC && !(pt_wr.we && tlb_we)))
        else $error("entry write outside execute cycle");
`endif

endmodule

// ===== bench/tb_virtual_address_translation_unit.sv =====
module tb_virtual_address_translation_unit;
    import vatu_pkg::*;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_BAD  = 2'd3;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int OP_TOP = (1 << OP_W) - 1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VA_W-1:0]    va;
        logic [1:0]         size;
        logic               wr;
        logic [IDX_W-1:0]   idx;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               valid;
        logic               ro;
    } mmu_cmd_t;

    typedef struct packed {
        logic [FAULT_W-1:0] fault;
        logic [PA_W-1:0]    pa;
        logic               dirty;
        logic               refd;
        logic [CNT_W-1:0]   count;
    } xlate_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       op = '0;
    logic [VA_W-1:0]       virt_addr = '0;
    logic [1:0]            access_size = '0;
    logic                  is_write = 1'b0;
    logic [IDX_W-1:0]      entry_index = '0;
    logic [PAGE_W-1:0]     entry_page = '0;
    logic [FRAME_W-1:0]    entry_frame = '0;
    logic                  entry_valid = 1'b0;
    logic                  entry_read_only = 1'b0;
    logic                  done;
    logic [FAULT_W-1:0]    fault;
    logic [PA_W-1:0]       phys_addr;
    logic                  dirty_bit;
    logic                  referenced_bit;
    logic [CNT_W-1:0]      reference_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the translation state
    pte_t             ptab_shadow [TABLE_DEPTH];
    tlbe_t            tlb_shadow [TLB_ENTRIES];
    logic             use_tlb_sh;
    logic [TEI_W-1:0] tei_sh;
    logic [LIMIT_W-1:0] limit_sh;

    xlate_res_t pending_results [$];
    int         fail_count = 0;

    virtual_address_translation_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .virt_addr       (virt_addr),
        .access_size     (access_size),
        .is_write        (is_write),
        .entry_index     (entry_index),
        .entry_page      (entry_page),
        .entry_frame     (entry_frame),
        .entry_valid     (entry_valid),
        .entry_read_only (entry_read_only),
        .done            (done),
        .fault           (fault),
        .phys_addr       (phys_addr),
        .dirty_bit       (dirty_bit),
        .referenced_bit  (referenced_bit),
        .reference_count (reference_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [VA_W-1:0] va_of(logic [VPN_W-1:0] vpn, logic [OFF_W-1:0] off);
        return {vpn, off};
    endfunction

    function automatic mmu_cmd_t xlate_cmd(logic [VA_W-1:0] va, logic [1:0] size, logic wr);
        mmu_cmd_t c;
        c = '0;
        c.op = OP_XLATE;
        c.va = va;
        c.size = size;
        c.wr = wr;
        return c;
    endfunction

    function automatic mmu_cmd_t entry_cmd(logic [OP_W-1:0] o, logic [IDX_W-1:0] idx,
                                           logic [PAGE_W-1:0] page,
                                           logic [FRAME_W-1:0] frame,
                                           logic valid, logic ro);
        mmu_cmd_t c;
        c = '0;
        c.op = o;
        c.idx = idx;
        c.page = page;
        c.frame = frame;
        c.valid = valid;
        c.ro = ro;
        return c;
    endfunction

    // frames mostly under the current limit so translations get through
    function automatic logic [FRAME_W-1:0] pick_frame();
        int top;
        top = (limit_sh > (1 << FRAME_W)) ? (1 << FRAME_W) : int'(limit_sh);
        if (top == 0 || $urandom_range(0, 9) == 0)
            return FRAME_W'($urandom());
        return FRAME_W'($urandom_range(0, top - 1));
    endfunction

    // computes the result of one command and applies its side effects
    function automatic xlate_res_t translate_and_update(mmu_cmd_t c);
        xlate_res_t r;
        pte_t e;
        tlbe_t t;
        logic [VPN_W-1:0] vpn;
        int hit;
        int lim;
        r = '0;
        e = '0;
        vpn = c.va[VA_W-1:OFF_W];
        hit = -1;
        lim = (tei_sh > TABLE_DEPTH) ? TABLE_DEPTH : int'(tei_sh);
        case (c.op)
            OP_XLATE:
            begin
                if (c.size == SZ_BAD || (c.size == SZ_WORD && c.va[1:0] != 2'b00) ||
                    (c.size == SZ_HALF && c.va[0]))
                    r.fault = FAULT_ADDR;
                else if (!use_tlb_sh && vpn >= lim)
                    r.fault = FAULT_ADDR;
                else
                begin
                    if (!use_tlb_sh)
                    begin
                        if (ptab_shadow[vpn[PTAB_AW-1:0]].valid)
                            hit = int'(vpn);
                    end
                    else
                    begin
                        // lowest matching slot wins
                        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
                            if (tlb_shadow[i].e.valid && tlb_shadow[i].page == vpn)
                                hit = i;
                    end
                    if (hit < 0)
                        r.fault = FAULT_PAGE;
                    else
                    begin
                        e = use_tlb_sh ? tlb_shadow[hit].e : ptab_shadow[hit];
                        if (e.ro && c.wr)
                            r.fault = FAULT_RO;
                        else if (e.frame >= limit_sh)
                            r.fault = FAULT_BUS;
                        else
                        begin
                            e.dirty = e.dirty | c.wr;
                            e.refd = 1'b1;
                            if (e.count != CNT_MAX)
                                e.count = e.count + 1'b1;
                            if (use_tlb_sh)
                                tlb_shadow[hit].e = e;
                            else
                                ptab_shadow[hit] = e;
                            r.pa = PA_W'({e.frame, c.va[OFF_W-1:0]});
                            r.dirty = e.dirty;
                            r.refd = e.refd;
                            r.count = e.count;
                        end
                    end
                end
            end
            OP_WR_PT, OP_RD_PT:
            begin
                if (c.idx >= TABLE_DEPTH)
                    r.fault = FAULT_ADDR;
                else if (c.op == OP_WR_PT)
                begin
                    e.frame = c.frame;
                    e.valid = c.valid;
                    e.ro = c.ro;
                    ptab_shadow[c.idx] = e;
                end
                else
                begin
                    e = ptab_shadow[c.idx];
                    r.pa = PA_W'({e.frame, {OFF_W{1'b0}}});
                    r.dirty = e.dirty;
                    r.refd = e.refd;
                    r.count = e.count;
                end
            end
            OP_WR_TLB, OP_RD_TLB:
            begin
                if (c.idx >= TLB_ENTRIES)
                    r.fault = FAULT_ADDR;
                else if (c.op == OP_WR_TLB)
                begin
                    t = '0;
                    t.page = c.page;
                    t.e.frame = c.frame;
                    t.e.valid = c.valid;
                    t.e.ro = c.ro;
                    tlb_shadow[c.idx] = t;
                end
                else
                begin
                    e = tlb_shadow[c.idx].e;
                    r.pa = PA_W'({e.frame, {OFF_W{1'b0}}});
                    r.dirty = e.dirty;
                    r.refd = e.refd;
                    r.count = e.count;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        xlate_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $error("result with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("fault", 32'(want.fault), 32'(fault));
                check_field("phys_addr", 32'(want.pa), 32'(phys_addr));
                check_field("dirty_bit", 32'(want.dirty), 32'(dirty_bit));
                check_field("referenced_bit", 32'(want.refd), 32'(referenced_bit));
                check_field("reference_count", 32'(want.count), 32'(reference_count));
            end
        end
    end

    // start stays high on return so a following command goes back to back
    task automatic send_cmd(mmu_cmd_t c);
        start <= 1'b1;
        op <= c.op;
        virt_addr <= c.va;
        access_size <= c.size;
        is_write <= c.wr;
        entry_index <= c.idx;
        entry_page <= c.page;
        entry_frame <= c.frame;
        entry_valid <= c.valid;
        entry_read_only <= c.ro;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(translate_and_update(c));
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // every command answers, so an empty queue means the block is idle
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_USE_TLB: use_tlb_sh = val[0];
            CFG_TEI:     tei_sh = val[TEI_W-1:0];
            CFG_LIMIT:   limit_sh = val[LIMIT_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic test_entry_ops();
        mmu_cmd_t c;
        // contents right after reset
        send_cmd(entry_cmd(OP_RD_PT, '0, '0, '0, 1'b0, 1'b0));
        send_cmd(entry_cmd(OP_RD_TLB, IDX_W'(TLB_ENTRIES - 1), '0, '0, 1'b0, 1'b0));
        send_cmd(entry_cmd(OP_WR_PT, '0, '1, 16'h007F, 1'b1, 1'b0));
        send_cmd(entry_cmd(OP_WR_PT, IDX_W'(TABLE_DEPTH - 1), '0, 16'hFFFF, 1'b1, 1'b1));
        send_cmd(entry_cmd(OP_WR_PT, IDX_W'(1), '0, 16'd5, 1'b0, 1'b0));
        send_cmd(entry_cmd(OP_WR_TLB, '0, '1, 16'd0, 1'b1, 1'b0));
        send_cmd(entry_cmd(OP_WR_TLB, IDX_W'(1), '1, 16'd9, 1'b1, 1'b1));
        // slot beyond the TLB
        send_cmd(entry_cmd(OP_WR_TLB, IDX_W'(TLB_ENTRIES), '0, 16'd1, 1'b1, 1'b0));
        send_cmd(entry_cmd(OP_RD_TLB, '1, '0, '0, 1'b0, 1'b0));
        send_cmd(entry_cmd(OP_RD_PT, IDX_W'(TABLE_DEPTH - 1), '0, '0, 1'b0, 1'b0));
        for (int k = OP_RD_TLB + 1; k <= OP_TOP; k++)
        begin
            c = '1;
            c.op = OP_W'(k);
            send_cmd(c);
        end
    endtask

    task automatic test_translate_faults();
        send_cmd(xlate_cmd(32'h0000_0003, SZ_BYTE, 1'b0));
        send_cmd(xlate_cmd(32'h0000_0002, SZ_HALF, 1'b1));
        send_cmd(xlate_cmd(32'h0000_0004, SZ_WORD, 1'b0));
        send_cmd(xlate_cmd(32'h0000_0001, SZ_HALF, 1'b0));
        send_cmd(xlate_cmd(32'h0000_0002, SZ_WORD, 1'b0));
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BAD, 1'b0));
        send_cmd(xlate_cmd(va_of(VPN_W'(1), '0), SZ_BYTE, 1'b0));
        send_cmd(xlate_cmd(va_of(VPN_W'(TABLE_DEPTH - 1), '0), SZ_BYTE, 1'b0));
        send_cmd(xlate_cmd(va_of(VPN_W'(TABLE_DEPTH - 1), '0), SZ_BYTE, 1'b1));
        send_cmd(xlate_cmd(32'hFFFF_FFFC, SZ_WORD, 1'b0));
        send_cmd(entry_cmd(OP_RD_PT, '0, '0, '0, 1'b0, 1'b0));
    endtask

    task automatic test_tlb_lookup();
        write_reg(CFG_USE_TLB, CFG_DATA_W'(1));
        send_cmd(xlate_cmd(32'hFFFF_FFFC, SZ_WORD, 1'b1));
        send_cmd(xlate_cmd(32'hFFFF_FFFF, SZ_BYTE, 1'b1));
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        send_cmd(entry_cmd(OP_WR_TLB, IDX_W'(2), '0, 16'd1, 1'b0, 1'b0));
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        send_cmd(entry_cmd(OP_RD_TLB, '0, '0, '0, 1'b0, 1'b0));
        send_cmd(entry_cmd(OP_RD_TLB, IDX_W'(1), '0, '0, 1'b0, 1'b0));
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_USE_TLB, '0);
        write_reg(CFG_TEI, '0);
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        write_reg(CFG_TEI, CFG_DATA_W'(1));
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        send_cmd(xlate_cmd(va_of(VPN_W'(1), '0), SZ_BYTE, 1'b0));
        // above the table depth the range is capped
        write_reg(CFG_TEI, CFG_DATA_W'(127));
        send_cmd(xlate_cmd(va_of(VPN_W'(TABLE_DEPTH), '0), SZ_BYTE, 1'b0));
        write_reg(CFG_LIMIT, CFG_DATA_W'(65536));
        send_cmd(xlate_cmd(va_of(VPN_W'(TABLE_DEPTH - 1), OFF_W'(8)), SZ_WORD, 1'b0));
        write_reg(CFG_LIMIT, CFG_DATA_W'(131071));
        send_cmd(xlate_cmd(va_of(VPN_W'(TABLE_DEPTH - 1), OFF_W'(127)), SZ_BYTE, 1'b0));
        write_reg(CFG_LIMIT, '0);
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        write_reg(CFG_LIMIT, CFG_DATA_W'(1));
        send_cmd(entry_cmd(OP_WR_PT, IDX_W'(2), '0, 16'd0, 1'b1, 1'b0));
        send_cmd(xlate_cmd(va_of(VPN_W'(2), OFF_W'(6)), SZ_HALF, 1'b1));
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        write_reg(CFG_SPARE, '1);
        send_cmd(xlate_cmd(32'h0000_0000, SZ_BYTE, 1'b0));
        write_reg(CFG_TEI, CFG_DATA_W'(64));
        write_reg(CFG_LIMIT, CFG_DATA_W'(128));
    endtask

    task automatic test_ref_count();
        send_cmd(entry_cmd(OP_WR_PT, IDX_W'(9), '0, 16'd3, 1'b1, 1'b0));
        repeat (16)
            send_cmd(xlate_cmd(va_of(VPN_W'(9), '0), SZ_BYTE, 1'b0));
        send_cmd(entry_cmd(OP_RD_PT, IDX_W'(9), '0, '0, 1'b0, 1'b0));
        drain();
    endtask

    task automatic test_random_traffic();
        mmu_cmd_t c;
        logic [95:0] raw;
        logic [PAGE_W-1:0] pool [8];
        logic [VPN_W-1:0] vpn;
        logic [OFF_W-1:0] off;
        int lim;
        int sel;
        int burst;
        for (int ph = 0; ph < 14; ph++)
        begin
            write_reg(CFG_USE_TLB, CFG_DATA_W'($urandom_range(0, 1)));
            sel = $urandom_range(0, 9);
            write_reg(CFG_TEI, CFG_DATA_W'((sel == 0) ? 0 : (sel == 1) ? 127 : (sel == 2) ? 1 :
                      (sel < 5) ? 64 : $urandom_range(2, 63)));
            sel = $urandom_range(0, 9);
            write_reg(CFG_LIMIT, CFG_DATA_W'((sel == 0) ? 0 : (sel == 1) ? 1 :
                      (sel == 2) ? 65536 : (sel == 3) ? 131071 : $urandom_range(16, 70000)));
            lim = (tei_sh > TABLE_DEPTH) ? TABLE_DEPTH : int'(tei_sh);
            for (int k = 0; k < 8; k++)
                pool[k] = PAGE_W'($urandom());
            if (ph % 3 == 0)
                pool[0] = '1;
            if (ph % 3 == 1)
                pool[1] = '0;

            // load the structure in use before the traffic
            if (use_tlb_sh)
            begin
                for (int s = 0; s < TLB_ENTRIES; s++)
                    send_cmd(entry_cmd(OP_WR_TLB, IDX_W'(s), pool[$urandom_range(0, 7)],
                                       pick_frame(), $urandom_range(0, 9) != 0,
                                       $urandom_range(0, 3) == 0));
            end
            else
            begin
                for (int s = 0; s < 8; s++)
                    send_cmd(entry_cmd(OP_WR_PT, IDX_W'($urandom_range(0, lim > 0 ? lim - 1 : 0)),
                                       '0, pick_frame(), $urandom_range(0, 9) != 0,
                                       $urandom_range(0, 3) == 0));
            end

            burst = 0;
            for (int k = 0; k < 90; k++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 16);
                    if (ph % 4 != 3)
                        pause($urandom_range(0, 4));
                end
                burst--;
                raw = {$urandom(), $urandom(), $urandom()};
                c = mmu_cmd_t'(raw[$bits(mmu_cmd_t)-1:0]);
                sel = $urandom_range(0, 99);
                if (sel < 68)
                begin
                    c.op = OP_XLATE;
                    c.size = ($urandom_range(0, 19) == 0) ? SZ_BAD : 2'($urandom_range(0, 2));
                    // a tenth keep a fully random address
                    if ($urandom_range(0, 9) != 0)
                    begin
                        vpn = use_tlb_sh ? pool[$urandom_range(0, 7)] :
                              VPN_W'($urandom_range(0, lim));
                        off = OFF_W'($urandom());
                        if ($urandom_range(0, 19) != 0)
                        begin
                            if (c.size == SZ_WORD)
                                off[1:0] = 2'b00;
                            else if (c.size == SZ_HALF)
                                off[0] = 1'b0;
                        end
                        c.va = va_of(vpn, off);
                    end
                end
                else if (sel < 95)
                begin
                    if (sel < 82)
                        c.op = (use_tlb_sh ^ ($urandom_range(0, 4) == 0)) ? OP_WR_TLB : OP_WR_PT;
                    else
                        c.op = (use_tlb_sh ^ ($urandom_range(0, 4) == 0)) ? OP_RD_TLB : OP_RD_PT;
                    if ($urandom_range(0, 7) != 0)
                        c.idx = (c.op == OP_WR_TLB || c.op == OP_RD_TLB) ?
                                IDX_W'($urandom_range(0, TLB_ENTRIES - 1)) :
                                IDX_W'($urandom_range(0, lim > 0 ? lim - 1 : 0));
                    c.page = pool[$urandom_range(0, 7)];
                    c.frame = pick_frame();
                    c.valid = $urandom_range(0, 9) != 0;
                    c.ro = $urandom_range(0, 3) == 0;
                end
                else
                    c.op = OP_W'($urandom_range(OP_RD_TLB + 1, OP_TOP));
                send_cmd(c);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            ptab_shadow[i] = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
            tlb_shadow[i] = '0;
        use_tlb_sh = 1'b0;
        tei_sh = TEI_W'(64);
        limit_sh = LIMIT_W'(128);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_entry_ops();
        test_translate_faults();
        test_tlb_lookup();
        test_config_extremes();
        test_ref_count();
        test_random_traffic();

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
